FILE: src/irfd_pkg.sv
// irfd_pkg: shared types, codes and the key lookup for the ir frame decoder
// and encoder count block. No dependencies.

package irfd_pkg;

    localparam int unsigned DATA_W  = 32;
    localparam int unsigned FLOOR_W = 4;
    localparam int unsigned CMD_W   = 2;
    localparam int unsigned CFG_IDX_W = 2;

    typedef logic [DATA_W-1:0]  t_word;
    typedef logic [FLOOR_W-1:0] t_floor;

    // event kinds; code 3 means nothing and falls to the default arm
    typedef enum logic [CMD_W-1:0] {
        CMD_ENC_A = 2'd0,
        CMD_ENC_B = 2'd1,
        CMD_IR    = 2'd2
    } t_cmd;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_GAP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_MIN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BIT_SPLIT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_MAX   = 2'd3;

    localparam t_word FRAME_GAP_RST = 32'd10000;
    localparam t_word ZERO_MIN_RST  = 32'd1000;
    localparam t_word BIT_SPLIT_RST = 32'd2000;
    localparam t_word ONE_MAX_RST   = 32'd3000;

    localparam t_floor FLOOR_MAX = 4'd9;

    typedef struct packed {
        logic   valid;
        t_floor floor_num;
    } t_key;

    // low byte of the frame to floor number
    function automatic t_key key_lookup(input logic [7:0] code);
        t_key k;
        k.valid     = 1'b1;
        k.floor_num = '0;
        case (code)
            8'h16: k.floor_num = 4'd0;
            8'h0C: k.floor_num = 4'd1;
            8'h18: k.floor_num = 4'd2;
            8'h5E: k.floor_num = 4'd3;
            8'h08: k.floor_num = 4'd4;
            8'h1C: k.floor_num = 4'd5;
            8'h5A: k.floor_num = 4'd6;
            8'h42: k.floor_num = 4'd7;
            8'h52: k.floor_num = 4'd8;
            8'h4A: k.floor_num = 4'd9;
            default: k.valid = 1'b0;
        endcase
        return k;
    endfunction

endpackage

FILE: src/irfd_if.sv
// irfd_evt_if / irfd_res_if: valid/ready channels for edge events and results
// depends on irfd_pkg

interface irfd_evt_if;
    logic              valid;
    logic              ready;
    logic [1:0]        cmd;
    logic              other_phase;
    irfd_pkg::t_word   stamp;

    modport source (output valid, output cmd, output other_phase, output stamp, input ready);
    modport sink   (input valid, input cmd, input other_phase, input stamp, output ready);
endinterface

interface irfd_res_if;
    logic                   valid;
    logic                   ready;
    logic signed [31:0]     position;
    irfd_pkg::t_word        frame_code;
    logic                   frame_done;
    irfd_pkg::t_floor       key_floor;
    logic                   key_valid;

    modport source (output valid, output position, output frame_code, output frame_done,
                    output key_floor, output key_valid, input ready);
    modport sink   (input valid, input position, input frame_code, input frame_done,
                    input key_floor, input key_valid, output ready);
endinterface

FILE: src/ir_frame_decoder_and_encoder_count.sv
// ir_frame_decoder_and_encoder_count: quadrature position counter and ir pulse
// distance frame receiver; depends on irfd_pkg and the channels in irfd_if.sv
//
//  channel   dir  transfer when          carries
//  i_evt     in   valid && ready         cmd, other_phase, stamp
//  o_res     out  valid && ready         position, frame_code, frame_done, key_*
//  cfg       in   i_cfg_we               i_cfg_idx, i_cfg_wdata
//
// one event per cycle unless o_res stalls; the result follows in the next cycle.
// the state update and result compute sit in one stage ahead of the result
// register, whose gap subtract and bound compares set the path.
// i_evt.ready is low only while a result is held and o_res.ready is low.
// synchronous active-low reset: position, stamp, code and bit count clear,
// the gap bounds return to 10000/1000/2000/3000.

module ir_frame_decoder_and_encoder_count #(
    parameter int unsigned FRAME_BITS = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [irfd_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  irfd_pkg::t_word                i_cfg_wdata,
    irfd_evt_if.sink                       i_evt,
    irfd_res_if.source                     o_res
);
    import irfd_pkg::*;

    localparam int unsigned CNT_W = $clog2(FRAME_BITS + 1);

    t_word r_frame_gap, r_zero_min, r_bit_split, r_one_max;

    t_word            r_count, n_count;
    t_word            r_last, n_last;
    t_word            r_shift, n_shift;
    logic [CNT_W-1:0] r_bits, n_bits;
    logic             n_done;
    t_key             n_key;

    logic             r_out_valid;
    t_word            r_pos, r_code;
    logic             r_done;
    t_key             r_key;

    t_word            diff, gap;
    logic [CNT_W-1:0] bits_inc;
    logic             accept;

    assign i_evt.ready = !r_out_valid || o_res.ready;
    assign accept      = i_evt.valid && i_evt.ready;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_gap <= FRAME_GAP_RST;
            r_zero_min  <= ZERO_MIN_RST;
            r_bit_split <= BIT_SPLIT_RST;
            r_one_max   <= ONE_MAX_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_FRAME_GAP: r_frame_gap <= i_cfg_wdata;
                CFG_ZERO_MIN:  r_zero_min  <= i_cfg_wdata;
                CFG_BIT_SPLIT: r_bit_split <= i_cfg_wdata;
                CFG_ONE_MAX:   r_one_max   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // gap is one short of the modular distance when the timer wrapped
    assign diff     = i_evt.stamp - r_last;
    assign gap      = (i_evt.stamp >= r_last) ? diff : diff - 32'd1;
    assign bits_inc = r_bits + CNT_W'(1);

    always_comb begin
        n_count = r_count;
        n_last  = r_last;
        n_shift = r_shift;
        n_bits  = r_bits;
        n_done  = 1'b0;
        n_key   = '0;
        case (i_evt.cmd)
            CMD_ENC_A: n_count = i_evt.other_phase ? r_count + 32'd1 : r_count - 32'd1;
            CMD_ENC_B: n_count = i_evt.other_phase ? r_count - 32'd1 : r_count + 32'd1;
            CMD_IR: begin
                n_last = i_evt.stamp;
                if (gap > r_frame_gap) begin
                    n_shift = '0;
                    n_bits  = '0;
                end else if (gap > r_zero_min && gap < r_bit_split) begin
                    n_shift = {r_shift[DATA_W-2:0], 1'b0};
                    n_bits  = bits_inc;
                end else if (gap > r_bit_split && gap < r_one_max) begin
                    n_shift = {r_shift[DATA_W-2:0], 1'b1};
                    n_bits  = bits_inc;
                end
                if (n_bits >= CNT_W'(FRAME_BITS)) begin
                    n_done = 1'b1;
                    n_bits = '0;
                    n_key  = key_lookup(n_shift[7:0]);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_last      <= '0;
            r_shift     <= '0;
            r_bits      <= '0;
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_count     <= n_count;
            r_last      <= n_last;
            r_shift     <= n_shift;
            r_bits      <= n_bits;
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pos  <= n_count;
            r_code <= n_shift;
            r_done <= n_done;
            r_key  <= n_key;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.position   = r_pos;
    assign o_res.frame_code = r_code;
    assign o_res.frame_done = r_done;
    assign o_res.key_floor  = r_key.floor_num;
    assign o_res.key_valid  = r_key.valid;

endmodule

FILE: src/irfd_checker.sv
// irfd_props: port-level checks on the result channel of the top level
// depends on irfd_pkg; bound to ir_frame_decoder_and_encoder_count below

module irfd_props (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input logic                i_in_ready,
    input logic                i_frame_done,
    input logic                i_key_valid,
    input irfd_pkg::t_floor    i_key_floor,
    input irfd_pkg::t_word     i_frame_code
);
    import irfd_pkg::*;

    // a stalled result stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_frame_code))
        else $error("result changed while stalled");

    // key only reported with a completed frame
    a_key_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_key_valid |-> i_frame_done)
        else $error("key valid without frame done");

    a_key_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_key_valid |-> i_key_floor <= FLOOR_MAX)
        else $error("key floor out of range");

    // an empty output slot always takes the next event
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with empty result slot");

    a_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind ir_frame_decoder_and_encoder_count irfd_props u_irfd_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_res.valid),
    .i_out_ready  (o_res.ready),
    .i_in_ready   (i_evt.ready),
    .i_frame_done (o_res.frame_done),
    .i_key_valid  (o_res.key_valid),
    .i_key_floor  (o_res.key_floor),
    .i_frame_code (o_res.frame_code)
);

FILE: verif/irfd_checker.sv
`timescale 1ns / 100ps
// irfd_checker: follows the encoder count and ir frame state from event transfers
// and checks every result transfer in order; depends on irfd_pkg

module irfd_checker #(
    parameter int unsigned FRAME_BITS = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [irfd_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  irfd_pkg::t_word                i_cfg_wdata,
    input  logic                           i_evt_valid,
    input  logic                           i_evt_ready,
    input  logic [irfd_pkg::CMD_W-1:0]     i_evt_cmd,
    input  logic                           i_evt_phase,
    input  irfd_pkg::t_word                i_evt_stamp,
    input  logic                           i_res_valid,
    input  logic                           i_res_ready,
    input  logic signed [31:0]             i_res_position,
    input  irfd_pkg::t_word                i_res_code,
    input  logic                           i_res_done,
    input  irfd_pkg::t_floor               i_res_floor,
    input  logic                           i_res_key_ok,
    output int                             o_pending,
    output int                             o_errors
);
    import irfd_pkg::*;

    // remote key bytes, floor 9 in the top byte down to floor 0 in the bottom
    localparam logic [79:0] FLOOR_KEYS = {8'h4A, 8'h52, 8'h42, 8'h5A, 8'h1C,
                                          8'h08, 8'h5E, 8'h18, 8'h0C, 8'h16};

    typedef struct packed {
        logic signed [31:0] position;
        t_word              code;
        logic               done;
        t_floor             floor_num;
        logic               key_ok;
    } t_result;

    t_word      frame_gap, zero_min, bit_split, one_max;
    t_word      enc_count, last_stamp, shift_code;
    logic [5:0] bits_seen;
    int         err_count = 0;
    t_result    expected_results[$];

    task automatic report_mismatch(input string field, input logic [31:0] want, got);
        $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
        err_count++;
    endtask

    always @(posedge i_clk) begin : track
        t_word   gap;
        t_result want;
        if (!i_rst_n) begin
            frame_gap  = FRAME_GAP_RST;
            zero_min   = ZERO_MIN_RST;
            bit_split  = BIT_SPLIT_RST;
            one_max    = ONE_MAX_RST;
            enc_count  = '0;
            last_stamp = '0;
            shift_code = '0;
            bits_seen  = '0;
            expected_results.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_FRAME_GAP: frame_gap = i_cfg_wdata;
                    CFG_ZERO_MIN:  zero_min  = i_cfg_wdata;
                    CFG_BIT_SPLIT: bit_split = i_cfg_wdata;
                    CFG_ONE_MAX:   one_max   = i_cfg_wdata;
                    default: ;
                endcase
            end

            if (i_res_valid && i_res_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: result transfer with nothing expected, actual position %h code %h",
                             $time, i_res_position, i_res_code);
                    err_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (i_res_position !== want.position)
                        report_mismatch("position", want.position, i_res_position);
                    if (i_res_code !== want.code)
                        report_mismatch("frame_code", want.code, i_res_code);
                    if (i_res_done !== want.done)
                        report_mismatch("frame_done", want.done, i_res_done);
                    if (i_res_floor !== want.floor_num)
                        report_mismatch("key_floor", want.floor_num, i_res_floor);
                    if (i_res_key_ok !== want.key_ok)
                        report_mismatch("key_valid", want.key_ok, i_res_key_ok);
                end
            end

            if (i_evt_valid && i_evt_ready) begin
                want.done      = 1'b0;
                want.floor_num = '0;
                want.key_ok    = 1'b0;
                case (i_evt_cmd)
                    CMD_ENC_A: enc_count = i_evt_phase ? enc_count + 32'd1 : enc_count - 32'd1;
                    CMD_ENC_B: enc_count = i_evt_phase ? enc_count - 32'd1 : enc_count + 32'd1;
                    CMD_IR: begin
                        // a wrapped timer gives one less than the modular distance
                        if (i_evt_stamp >= last_stamp)
                            gap = i_evt_stamp - last_stamp;
                        else
                            gap = ~last_stamp + i_evt_stamp;
                        last_stamp = i_evt_stamp;
                        if (gap > frame_gap) begin
                            shift_code = '0;
                            bits_seen  = '0;
                        end else if (gap > zero_min && gap < bit_split) begin
                            shift_code = {shift_code[30:0], 1'b0};
                            bits_seen  = bits_seen + 6'd1;
                        end else if (gap > bit_split && gap < one_max) begin
                            shift_code = {shift_code[30:0], 1'b1};
                            bits_seen  = bits_seen + 6'd1;
                        end
                        if (bits_seen >= FRAME_BITS) begin
                            want.done = 1'b1;
                            bits_seen = '0;
                            for (int f = 0; f < 10; f++) begin
                                if (FLOOR_KEYS[f*8 +: 8] == shift_code[7:0]) begin
                                    want.floor_num = f[FLOOR_W-1:0];
                                    want.key_ok    = 1'b1;
                                end
                            end
                        end
                    end
                    default: ;
                endcase
                want.position = enc_count;
                want.code     = shift_code;
                expected_results.push_back(want);
            end
        end
        o_pending <= expected_results.size();
        o_errors  <= err_count;
    end

endmodule

FILE: verif/tb_ir_frame_decoder_and_encoder_count.sv
`timescale 1ns / 100ps
// tb_ir_frame_decoder_and_encoder_count: drives encoder and ir edge events under
// several gap bound settings with random stalls; depends on irfd_pkg, irfd_if.sv,
// the block and irfd_checker

module tb_ir_frame_decoder_and_encoder_count;
    import irfd_pkg::*;

    localparam int unsigned FRAME_BITS = 32;
    localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 4;
    localparam logic [79:0] FLOOR_KEYS = {8'h4A, 8'h52, 8'h42, 8'h5A, 8'h1C,
                                          8'h08, 8'h5E, 8'h18, 8'h0C, 8'h16};
    localparam logic [CFG_IDX_W-1:0] CFG_ORDER [4] = '{CFG_FRAME_GAP, CFG_ZERO_MIN,
                                                       CFG_BIT_SPLIT, CFG_ONE_MAX};

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    t_word                cfg_wdata;

    int    pending;
    int    errors;
    int    cycles = 0;
    int    sent = 0;
    bit    quiet = 1'b0;
    t_word gap_cfg, zmin_cfg, split_cfg, omax_cfg;
    t_word last_ir;

    irfd_evt_if evt ();
    irfd_res_if res ();

    ir_frame_decoder_and_encoder_count #(
        .FRAME_BITS (FRAME_BITS)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata),
        .i_evt       (evt),
        .o_res       (res)
    );

    irfd_checker #(
        .FRAME_BITS (FRAME_BITS)
    ) i_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_idx      (cfg_idx),
        .i_cfg_wdata    (cfg_wdata),
        .i_evt_valid    (evt.valid),
        .i_evt_ready    (evt.ready),
        .i_evt_cmd      (evt.cmd),
        .i_evt_phase    (evt.other_phase),
        .i_evt_stamp    (evt.stamp),
        .i_res_valid    (res.valid),
        .i_res_ready    (res.ready),
        .i_res_position (res.position),
        .i_res_code     (res.frame_code),
        .i_res_done     (res.frame_done),
        .i_res_floor    (res.key_floor),
        .i_res_key_ok   (res.key_valid),
        .o_pending      (pending),
        .o_errors       (errors)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // mostly back to back, some short gaps, a few long ones
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    initial begin : result_ready
        int left;
        bit lvl;
        left = 0;
        lvl  = 1'b1;
        res.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (quiet) begin
                lvl = 1'b1;
            end else if (left == 0) begin
                lvl  = ($urandom_range(0, 99) < 65);
                left = idle_len();
            end else begin
                left--;
            end
            res.ready <= lvl;
        end
    end

    // every task below starts and ends just after a rising edge
    task automatic send_evt(input logic [CMD_W-1:0] cmd, input logic phase,
                            input t_word stamp);
        int idle;
        idle = quiet ? 0 : idle_len();
        if (idle > 0) begin
            evt.valid <= 1'b0;
            repeat (idle) @(posedge i_clk);
        end
        evt.valid       <= 1'b1;
        evt.cmd         <= cmd;
        evt.other_phase <= phase;
        evt.stamp       <= stamp;
        do @(posedge i_clk); while (!evt.ready);
        sent++;
    endtask

    task automatic send_ir_stamp(input t_word stamp);
        send_evt(CMD_IR, $urandom_range(0, 1), stamp);
        last_ir = stamp;
    endtask

    // a wrapped timer measures one short, so step one further
    task automatic send_ir_gap(input t_word gap);
        t_word stamp;
        stamp = last_ir + gap;
        if (stamp < last_ir)
            stamp = stamp + 1;
        send_ir_stamp(stamp);
    endtask

    task automatic send_enc();
        send_evt($urandom_range(0, 1) ? CMD_ENC_B : CMD_ENC_A, $urandom_range(0, 1),
                 $urandom);
    endtask

    // gap strictly inside (lo, hi), hugging an edge now and then
    function automatic bit pick_gap(input t_word lo, hi, output t_word gap);
        longint unsigned span;
        int r;
        gap = '0;
        if (hi <= lo || hi - lo < 2)
            return 1'b0;
        span = hi - lo - 1;
        r = $urandom_range(0, 9);
        if (r == 0)
            gap = lo + 1;
        else if (r == 1)
            gap = hi - 1;
        else
            gap = lo + 1 + t_word'($urandom % span);
        return 1'b1;
    endfunction

    task automatic send_bit(input logic b);
        t_word gap;
        bit ok;
        ok = b ? pick_gap(split_cfg, omax_cfg, gap) : pick_gap(zmin_cfg, split_cfg, gap);
        if (!ok)
            gap = $urandom;
        send_ir_gap(gap);
    endtask

    // leader gap then 32 bits msb first, with encoder edges and bound-equal gaps mixed in
    task automatic send_frame();
        t_word code;
        t_word extra;
        code = $urandom;
        if ($urandom_range(0, 1))
            code[7:0] = FLOOR_KEYS[$urandom_range(0, 9)*8 +: 8];
        if (gap_cfg != '1) begin
            extra = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 20000);
            if (gap_cfg > ~extra - 1)
                extra = 0;
            send_ir_gap(gap_cfg + 1 + extra);
        end
        for (int i = FRAME_BITS - 1; i >= 0; i--) begin
            if ($urandom_range(0, 9) == 0)
                send_enc();
            if ($urandom_range(0, 29) == 0)
                send_ir_gap(split_cfg);
            // an occasional frame broken off midway
            if ($urandom_range(0, 79) == 0)
                return;
            send_bit(code[i]);
        end
    endtask

    task automatic send_noise();
        case ($urandom_range(0, 4))
            0: send_evt(CMD_NONE, $urandom_range(0, 1), $urandom);
            1: send_ir_stamp($urandom);
            2: send_ir_gap(0);
            3: begin
                case ($urandom_range(0, 3))
                    0: send_ir_gap(gap_cfg);
                    1: send_ir_gap(zmin_cfg);
                    2: send_ir_gap(split_cfg);
                    default: send_ir_gap(omax_cfg);
                endcase
            end
            default: send_ir_gap($urandom_range(0, 4000));
        endcase
    endtask

    task automatic run_random(input int n_items);
        int stop;
        int r;
        stop = sent + n_items;
        while (sent < stop) begin
            r = $urandom_range(0, 99);
            if (r < 55)
                send_frame();
            else if (r < 80)
                repeat ($urandom_range(1, 8)) send_enc();
            else
                send_noise();
        end
    endtask

    // sender holds off until every result is back, then lets the pipe settle
    task automatic wait_idle();
        evt.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_config(input t_word g, z, s, o);
        t_word vals [4];
        vals = '{g, z, s, o};
        for (int k = 0; k < 4; k++) begin
            cfg_we    <= 1'b1;
            cfg_idx   <= CFG_ORDER[k];
            cfg_wdata <= vals[k];
            @(posedge i_clk);
        end
        cfg_we    <= 1'b0;
        gap_cfg   = g;
        zmin_cfg  = z;
        split_cfg = s;
        omax_cfg  = o;
    endtask

    initial begin : stimulus
        t_word z, s, o;
        i_rst_n         <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_idx         <= CFG_FRAME_GAP;
        cfg_wdata       <= '0;
        evt.valid       <= 1'b0;
        evt.cmd         <= CMD_ENC_A;
        evt.other_phase <= 1'b0;
        evt.stamp       <= '0;
        gap_cfg   = FRAME_GAP_RST;
        zmin_cfg  = ZERO_MIN_RST;
        split_cfg = BIT_SPLIT_RST;
        omax_cfg  = ONE_MAX_RST;
        last_ir   = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // encoder directions, count going negative, unused command
        send_evt(CMD_ENC_A, 1'b1, '1);
        send_evt(CMD_ENC_A, 1'b0, '0);
        send_evt(CMD_ENC_A, 1'b0, $urandom);
        send_evt(CMD_ENC_B, 1'b1, $urandom);
        send_evt(CMD_ENC_B, 1'b0, $urandom);
        send_evt(CMD_NONE, 1'b1, '1);
        // gaps on and around every bound at reset settings
        send_ir_stamp('0);
        send_ir_gap(FRAME_GAP_RST + 1);
        send_ir_gap(ZERO_MIN_RST);
        send_ir_gap(ZERO_MIN_RST + 1);
        send_ir_gap(BIT_SPLIT_RST);
        send_ir_gap(BIT_SPLIT_RST - 1);
        send_ir_gap(BIT_SPLIT_RST + 1);
        send_ir_gap(ONE_MAX_RST);
        send_ir_gap(ONE_MAX_RST - 1);
        send_ir_gap(FRAME_GAP_RST);
        // timer extremes and wraparound
        send_ir_stamp('1);
        send_ir_stamp(32'd1500);
        send_ir_stamp(32'hFFFF_FFFE);
        send_ir_stamp(32'hFFFF_FFFE);
        send_ir_stamp(32'd1);
        send_evt(CMD_NONE, 1'b0, '0);
        run_random(110);
        wait_idle();

        // widest windows, no gap can start a frame
        set_config('1, '0, 32'h8000_0000, '1);
        last_ir = 32'hFFFF_F000;
        send_ir_stamp(last_ir);
        run_random(90);
        wait_idle();

        // all bounds zero: any nonzero gap restarts the frame
        set_config('0, '0, '0, '0);
        run_random(40);
        wait_idle();

        z = $urandom_range(0, 300);
        s = z + 2 + $urandom_range(0, 400);
        o = s + 2 + $urandom_range(0, 400);
        set_config(o + $urandom_range(0, 2000), z, s, o);
        run_random(110);
        wait_idle();

        set_config($urandom, $urandom, $urandom, $urandom);
        run_random(50);
        wait_idle();

        // back to reset values without any stalls
        quiet = 1'b1;
        set_config(FRAME_GAP_RST, ZERO_MIN_RST, BIT_SPLIT_RST, ONE_MAX_RST);
        run_random(80);
        wait_idle();
        quiet = 1'b0;

        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
